FILE: rtl/assert_macros.svh
// Assertion helpers used by the compensation core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Types and constants of the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int DIV_W     = 32;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int IN_DW     = 40;
  localparam int OUT_DW    = 56;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_AC1_AC2 = 3'd0;
  localparam logic [CFG_AW-1:0] REG_AC3_AC4 = 3'd1;
  localparam logic [CFG_AW-1:0] REG_AC5_AC6 = 3'd2;
  localparam logic [CFG_AW-1:0] REG_B1_B2   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_MC_MD   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_OSS     = 3'd5;

  // Reset values of the calibration registers
  localparam logic [31:0] RST_AC1_AC2 = 32'h0198FFB8;
  localparam logic [31:0] RST_AC3_AC4 = 32'hC7D17FE5;
  localparam logic [31:0] RST_AC5_AC6 = 32'h7FF55A71;
  localparam logic [31:0] RST_B1_B2   = 32'h182E0004;
  localparam logic [31:0] RST_MC_MD   = 32'hDDF90B34;

  // Scheme constants
  localparam logic [31:0] B6_OFFSET   = 32'd4000;
  localparam logic [31:0] P_SQ_GAIN   = 32'd3038;
  localparam logic [31:0] P_LIN_GAIN  = 32'd7357;
  localparam logic [31:0] P_BIAS      = 32'd3791;
  localparam logic [31:0] B7_SCALE    = 32'd50000;
  localparam logic [31:0] B4_BIAS     = 32'd32768;
  localparam logic [15:0] DIV10_RECIP = 16'd52429;   // ceil(2^19 / 10)
  localparam logic [19:0] P_MAX       = 20'hFFFFF;

  typedef struct packed {
    logic [31:0] x1;
    logic [18:0] up;
    logic        neg;
    logic        dz;
  } div1_pay_t;

  typedef struct packed {
    logic        fault;
    logic        big;
    logic [15:0] tenths;
    logic [12:0] whole;
  } div2_pay_t;

endpackage

FILE: rtl/bsc_udiv.sv
// ----------------------------------------------------------------------------
// bsc_udiv
// Pipelined unsigned restoring divider, one quotient bit per stage,
// with a side payload that travels beside each item.
// ----------------------------------------------------------------------------
module bsc_udiv #(
  parameter int W  = 32,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  num,
  input  logic [W-1:0]  den,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [W-1:0]  quot,
  output logic [PW-1:0] out_pay
);

  logic          v_r   [W];
  logic [W-1:0]  rem_r [W];
  logic [W-1:0]  q_r   [W];
  logic [W-1:0]  den_r [W];
  logic [PW-1:0] pay_r [W];

  genvar i;
  for (i = 0; i < W; i++) begin : g_stage
    logic          v_src;
    logic [W-1:0]  r_src;
    logic [W-1:0]  q_src;
    logic [W-1:0]  d_src;
    logic [PW-1:0] p_src;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign v_src = in_valid;
      assign r_src = '0;
      assign q_src = num;
      assign d_src = den;
      assign p_src = in_pay;
    end else begin : g_next
      assign v_src = v_r[i-1];
      assign r_src = rem_r[i-1];
      assign q_src = q_r[i-1];
      assign d_src = den_r[i-1];
      assign p_src = pay_r[i-1];
    end

    assign trial = {r_src, q_src[W-1]};
    assign diff  = trial - {1'b0, d_src};
    assign ge    = (trial >= {1'b0, d_src});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[W-1:0] : trial[W-1:0];
        q_r[i]   <= {q_src[W-2:0], ge};
        den_r[i] <= d_src;
        pay_r[i] <= p_src;
      end
    end
  end

  assign out_valid = v_r[W-1];
  assign quot      = q_r[W-1];
  assign out_pay   = pay_r[W-1];

endmodule

FILE: rtl/barometric_sensor_compensation_core.sv
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_core
// Integer temperature and pressure compensation of a barometric sensor.
// ----------------------------------------------------------------------------
// Takes one raw temperature / raw pressure pair per item and returns the
// temperature in tenths and whole degrees C plus the pressure in Pa. The
// block is fully pipelined: it accepts one item every clock cycle and each
// item passes through 77 register stages (3 arithmetic stages, a 32-stage
// divider for B5, 7 more stages, a 32-stage divider for the pressure term,
// then 3 stages ending in the output register). Both dividers produce one
// quotient bit per stage, which sets the latency. The whole pipeline
// stalls together while a result waits at the output. fault marks items
// whose X1 + md or B4 was zero; their other fields are zero. Calibration
// writes are taken at any time but should only be made while the pipeline
// is empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module barometric_sensor_compensation_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: raw_temperature[15:0], raw_pressure[34:16], zero pad
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bsc_pkg::IN_DW-1:0]     in_tdata,
  // out_tdata: temp_tenths[15:0], temp_whole[28:16], pressure_pa[48:29], pad
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bsc_pkg::OUT_DW-1:0]    out_tdata,
  // out_tuser: fault
  output logic                          out_tuser,
  input  logic                          cfg_we,
  input  logic [bsc_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [bsc_pkg::CFG_DW-1:0]    cfg_wdata
);
  import bsc_pkg::*;

  // --------------------------------------------------------------------------
  // Calibration registers
  // --------------------------------------------------------------------------
  logic [31:0] ac12_r, ac34_r, ac56_r, b12_r, mcmd_r;
  logic [1:0]  oss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac12_r <= RST_AC1_AC2;
      ac34_r <= RST_AC3_AC4;
      ac56_r <= RST_AC5_AC6;
      b12_r  <= RST_B1_B2;
      mcmd_r <= RST_MC_MD;
      oss_r  <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_AC1_AC2: ac12_r <= cfg_wdata;
        REG_AC3_AC4: ac34_r <= cfg_wdata;
        REG_AC5_AC6: ac56_r <= cfg_wdata;
        REG_B1_B2:   b12_r  <= cfg_wdata;
        REG_MC_MD:   mcmd_r <= cfg_wdata;
        REG_OSS:     oss_r  <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Coefficients widened to 32 bits
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{ac12_r[31]}}, ac12_r[31:16]};
  assign ac2 = {{16{ac12_r[15]}}, ac12_r[15:0]};
  assign ac3 = {{16{ac34_r[31]}}, ac34_r[31:16]};
  assign ac4 = {16'd0, ac34_r[15:0]};
  assign ac5 = {16'd0, ac56_r[31:16]};
  assign ac6 = {16'd0, ac56_r[15:0]};
  assign b1  = {{16{b12_r[31]}}, b12_r[31:16]};
  assign b2  = {{16{b12_r[15]}}, b12_r[15:0]};
  assign mc  = {{16{mcmd_r[31]}}, mcmd_r[31:16]};
  assign md  = {{16{mcmd_r[15]}}, mcmd_r[15:0]};

  // Whole pipeline moves together; it holds while the output waits.
  logic adv;
  logic out_valid_r;
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // --------------------------------------------------------------------------
  // Stage 1: UT - ac6
  // --------------------------------------------------------------------------
  logic        v1_r;
  logic [31:0] s1_diff_r;
  logic [18:0] s1_up_r;

  // --------------------------------------------------------------------------
  // Stage 2: X1 = ((UT - ac6) * ac5) >> 15
  // --------------------------------------------------------------------------
  logic        v2_r;
  logic [31:0] s2_x1_r;
  logic [18:0] s2_up_r;
  logic [31:0] s2_prod;
  assign s2_prod = s1_diff_r * ac5;

  // --------------------------------------------------------------------------
  // Stage 3: operands of (mc << 11) / (X1 + md) as magnitudes and sign
  // --------------------------------------------------------------------------
  logic        v3_r;
  logic [31:0] s3_num_r, s3_den_r;
  div1_pay_t   s3_pay_r;
  logic [31:0] s3_d, s3_n;
  assign s3_d = s2_x1_r + md;
  assign s3_n = mc << 11;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_diff_r    <= {16'd0, in_tdata[15:0]} - ac6;
      s1_up_r      <= in_tdata[34:16];
      s2_x1_r      <= 32'($signed(s2_prod) >>> 15);
      s2_up_r      <= s1_up_r;
      s3_num_r     <= s3_n[31] ? (32'd0 - s3_n) : s3_n;
      s3_den_r     <= s3_d[31] ? (32'd0 - s3_d) : s3_d;
      s3_pay_r.x1  <= s2_x1_r;
      s3_pay_r.up  <= s2_up_r;
      s3_pay_r.neg <= s3_n[31] ^ s3_d[31];
      s3_pay_r.dz  <= (s3_d == 32'd0);
    end
  end

  // --------------------------------------------------------------------------
  // Divider 1: quotient magnitude of the B5 term
  // --------------------------------------------------------------------------
  logic        d1_valid;
  logic [31:0] d1_quot;
  div1_pay_t   d1_pay;

  bsc_udiv #(
    .W  (DIV_W),
    .PW ($bits(div1_pay_t))
  ) u_div_b5 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v3_r),
    .num       (s3_num_r),
    .den       (s3_den_r),
    .in_pay    (s3_pay_r),
    .out_valid (d1_valid),
    .quot      (d1_quot),
    .out_pay   (d1_pay)
  );

  // --------------------------------------------------------------------------
  // Stage 4: B5 = X1 + signed quotient
  // --------------------------------------------------------------------------
  logic        v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r;
  logic [31:0] s4_b5_r;
  logic [18:0] s4_up_r;
  logic        s4_dz_r;

  // Stage 5: B6 and the saturated temperature in tenths
  logic [31:0] s5_b6_r;
  logic [15:0] s5_tenths_r;
  logic [18:0] s5_up_r;
  logic        s5_dz_r;
  logic [31:0] s5_t32;
  logic [15:0] s5_tsat;
  assign s5_t32 = 32'($signed(s4_b5_r + 32'd8) >>> 4);
  always_comb begin
    if ($signed(s5_t32) > 32'sd32767) begin
      s5_tsat = 16'h7FFF;
    end else if ($signed(s5_t32) < -32'sd32768) begin
      s5_tsat = 16'h8000;
    end else begin
      s5_tsat = s5_t32[15:0];
    end
  end

  // Stage 6: sq = (B6 * B6) >> 12
  logic [31:0] s6_sq_r, s6_b6_r;
  logic [15:0] s6_tenths_r;
  logic [18:0] s6_up_r;
  logic        s6_dz_r;
  logic [31:0] s6_prod;
  assign s6_prod = s5_b6_r * s5_b6_r;

  // Stage 7: the four coefficient products
  logic [31:0] s7_m1_r, s7_m2_r, s7_m3_r, s7_m4_r;
  logic [15:0] s7_tenths_r;
  logic [18:0] s7_up_r;
  logic        s7_dz_r;
  logic [31:0] s7_p1, s7_p2, s7_p3, s7_p4;
  assign s7_p1 = b2 * s6_sq_r;
  assign s7_p2 = ac2 * s6_b6_r;
  assign s7_p3 = ac3 * s6_b6_r;
  assign s7_p4 = b1 * s6_sq_r;

  // Stage 8: B3 and the B4 multiplicand
  logic [31:0] s8_b3_r, s8_tb_r;
  logic [15:0] s8_tenths_r;
  logic [18:0] s8_up_r;
  logic        s8_dz_r;
  logic [31:0] s8_v, s8_x3b;
  assign s8_v   = (((ac1 << 2) + s7_m1_r + s7_m2_r) << oss_r) + 32'd2;
  assign s8_x3b = 32'($signed(s7_m3_r + s7_m4_r + 32'd2) >>> 2);

  // Stage 9: B4 and B7
  logic [31:0] s9_b4_r, s9_b7_r;
  logic [15:0] s9_tenths_r;
  logic        s9_dz_r;
  logic [31:0] s9_pb4, s9_pb7;
  assign s9_pb4 = ac4 * s8_tb_r;
  assign s9_pb7 = ({13'd0, s8_up_r} - s8_b3_r) * (B7_SCALE >> oss_r);

  // Stage 10: divider operands, fault and whole degrees
  logic [31:0] s10_num_r, s10_den_r;
  div2_pay_t   s10_pay_r;
  logic        s10_neg;
  logic [16:0] s10_mag;
  logic [32:0] s10_wprod;
  logic [12:0] s10_wq;
  assign s10_neg   = s9_tenths_r[15];
  assign s10_mag   = s10_neg ? (17'd0 - {1'b1, s9_tenths_r}) : {1'b0, s9_tenths_r};
  assign s10_wprod = s10_mag * DIV10_RECIP;
  assign s10_wq    = s10_wprod[31:19];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
    end else if (adv) begin
      v4_r  <= d1_valid;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_b5_r     <= d1_pay.x1 + (d1_pay.neg ? (32'd0 - d1_quot) : d1_quot);
      s4_up_r     <= d1_pay.up;
      s4_dz_r     <= d1_pay.dz;

      s5_b6_r     <= s4_b5_r - B6_OFFSET;
      s5_tenths_r <= s5_tsat;
      s5_up_r     <= s4_up_r;
      s5_dz_r     <= s4_dz_r;

      s6_sq_r     <= 32'($signed(s6_prod) >>> 12);
      s6_b6_r     <= s5_b6_r;
      s6_tenths_r <= s5_tenths_r;
      s6_up_r     <= s5_up_r;
      s6_dz_r     <= s5_dz_r;

      s7_m1_r     <= 32'($signed(s7_p1) >>> 11);
      s7_m2_r     <= 32'($signed(s7_p2) >>> 11);
      s7_m3_r     <= 32'($signed(s7_p3) >>> 13);
      s7_m4_r     <= 32'($signed(s7_p4) >>> 16);
      s7_tenths_r <= s6_tenths_r;
      s7_up_r     <= s6_up_r;
      s7_dz_r     <= s6_dz_r;

      // truncating divide by 4: bias negatives before the shift
      s8_b3_r     <= 32'($signed(s8_v + (s8_v[31] ? 32'd3 : 32'd0)) >>> 2);
      s8_tb_r     <= s8_x3b + B4_BIAS;
      s8_tenths_r <= s7_tenths_r;
      s8_up_r     <= s7_up_r;
      s8_dz_r     <= s7_dz_r;

      s9_b4_r     <= s9_pb4 >> 15;
      s9_b7_r     <= s9_pb7;
      s9_tenths_r <= s8_tenths_r;
      s9_dz_r     <= s8_dz_r;

      // B7 with its top bit set is divided first, doubled after
      s10_num_r        <= s9_b7_r[31] ? s9_b7_r : (s9_b7_r << 1);
      s10_den_r        <= s9_b4_r;
      s10_pay_r.fault  <= s9_dz_r || (s9_b4_r == 32'd0);
      s10_pay_r.big    <= s9_b7_r[31];
      s10_pay_r.tenths <= s9_tenths_r;
      s10_pay_r.whole  <= s10_neg ? (13'd0 - s10_wq) : s10_wq;
    end
  end

  // --------------------------------------------------------------------------
  // Divider 2: pressure term B7 / B4
  // --------------------------------------------------------------------------
  logic        d2_valid;
  logic [31:0] d2_quot;
  div2_pay_t   d2_pay;

  bsc_udiv #(
    .W  (DIV_W),
    .PW ($bits(div2_pay_t))
  ) u_div_p (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v10_r),
    .num       (s10_num_r),
    .den       (s10_den_r),
    .in_pay    (s10_pay_r),
    .out_valid (d2_valid),
    .quot      (d2_quot),
    .out_pay   (d2_pay)
  );

  // --------------------------------------------------------------------------
  // Stage 11: p, (p >> 8)^2 and 7357 * p
  // --------------------------------------------------------------------------
  logic        v11_r, v12_r;
  logic [31:0] s11_p_r, s11_sq_r, s11_lin_r;
  div2_pay_t   s11_pay_r;
  logic [31:0] s11_p, s11_a;
  assign s11_p = d2_pay.big ? (d2_quot << 1) : d2_quot;
  assign s11_a = 32'($signed(s11_p) >>> 8);

  // Stage 12: scaled square term and truncating /65536 of -7357 * p
  logic [31:0] s12_p_r, s12_x1_r, s12_x2_r;
  div2_pay_t   s12_pay_r;
  logic [31:0] s12_prod, s12_neg;
  assign s12_prod = s11_sq_r * P_SQ_GAIN;
  assign s12_neg  = 32'd0 - s11_lin_r;

  // Stage 13: final correction, saturation, output register
  logic [31:0] s13_pf;
  logic [19:0] s13_psat;
  logic [15:0] out_tenths_r;
  logic [12:0] out_whole_r;
  logic [19:0] out_press_r;
  logic        out_fault_r;
  assign s13_pf = s12_p_r + 32'($signed(s12_x1_r + s12_x2_r + P_BIAS) >>> 4);
  always_comb begin
    if (s13_pf[31]) begin
      s13_psat = 20'd0;
    end else if (s13_pf > {12'd0, P_MAX}) begin
      s13_psat = P_MAX;
    end else begin
      s13_psat = s13_pf[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v11_r       <= 1'b0;
      v12_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v11_r       <= d2_valid;
      v12_r       <= v11_r;
      out_valid_r <= v12_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s11_p_r      <= s11_p;
      s11_sq_r     <= s11_a * s11_a;
      s11_lin_r    <= P_LIN_GAIN * s11_p;
      s11_pay_r    <= d2_pay;

      s12_p_r      <= s11_p_r;
      s12_x1_r     <= 32'($signed(s12_prod) >>> 16);
      s12_x2_r     <= 32'($signed(s12_neg + (s12_neg[31] ? 32'h0000FFFF : 32'd0)) >>> 16);
      s12_pay_r    <= s11_pay_r;

      out_fault_r  <= s12_pay_r.fault;
      out_tenths_r <= s12_pay_r.fault ? 16'd0 : s12_pay_r.tenths;
      out_whole_r  <= s12_pay_r.fault ? 13'd0 : s12_pay_r.whole;
      out_press_r  <= s12_pay_r.fault ? 20'd0 : s13_psat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_press_r, out_whole_r, out_tenths_r};
  assign out_tuser  = out_fault_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BSC_ASSERT_NOW(a_fault_zero, out_tvalid && out_tuser, out_tdata == '0,
    "faulted item carries nonzero fields")
  `BSC_ASSERT_NOW(a_whole_sign, out_tvalid && !out_tuser,
    out_tdata[15] == out_tdata[28] || out_tdata[28:16] == 13'd0,
    "whole degrees sign disagrees with tenths")
  `BSC_ASSERT_NEXT(a_hold, out_tvalid && !out_tready && !in_tready,
    v12_r == $past(v12_r) && v3_r == $past(v3_r),
    "pipeline moved while stalled")

endmodule
